// ===== rtl/sagd_pkg.sv =====
// Shared types, constants and coefficient table for the glide-delay allpass shaper.
package sagd_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int MAX_DELAY  = 1501;
    localparam int DEPTH      = MAX_DELAY + 1;
    localparam int ADDR_W     = 11;
    localparam int SNAP_GAP   = 1500;

    localparam logic [30:0] GAIN_Q31   = 31'd1327217885;
    localparam logic [16:0] WET_FULL   = 17'd65536;
    localparam logic [28:0] SOFT_CLAMP = 29'h1000_0000;
    localparam logic [32:0] SIN_C0     = 33'd852176;
    localparam logic [32:0] COS_C0     = 33'd9;
    localparam logic [2:0]  SIN_LAST_K = 3'd2;
    localparam logic [2:0]  COS_LAST_K = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY_TARGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WET_LEVEL    = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLR, OP_LOAD, OP_RD0, OP_RDG, OP_WRG,
        OP_MSQ, OP_USET, OP_MHORN, OP_HPOST, OP_MFIN_S, OP_SINF,
        OP_RDA, OP_MG1, OP_AP1, OP_WRX, OP_MG2, OP_AP2, OP_RDB, OP_ADD,
        OP_PREC, OP_COSF, OP_MX1, OP_MXP1, OP_MX2, OP_MXP2, OP_FIN
    } t_op;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_SQ, ST_USET, ST_HMUL, ST_HPOST, ST_FMUL, ST_FPOST,
        ST_RD0, ST_RDG, ST_WRG, ST_RDA, ST_MG1, ST_AP1, ST_WRX, ST_MG2, ST_AP2,
        ST_RDB, ST_ADD, ST_PREC, ST_MX1, ST_MXP1, ST_MX2, ST_MXP2, ST_FIN
    } t_state;

    typedef struct packed {
        t_op        op;
        logic       cos_sel;
        logic [2:0] k;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic glide_act;
        logic out_free;
    } t_sts;

    // Horner coefficients, Q32; sine uses k 0..2, 1-cos uses k 0..4
    function automatic logic [32:0] horner_coef(input logic cos_sel, input logic [2:0] k);
        logic [32:0] c;
        c = '0;
        if (cos_sel) begin
            case (k)
                3'd0:    c = 33'd1184;
                3'd1:    c = 33'd106522;
                3'd2:    c = 33'd5965232;
                3'd3:    c = 33'd178956971;
                default: c = 33'd2147483648;
            endcase
        end else begin
            case (k)
                3'd0:    c = 33'd35791394;
                3'd1:    c = 33'd715827883;
                default: c = 33'h1_0000_0000;
            endcase
        end
        return c;
    endfunction

endpackage

// ===== rtl/saturated_allpass_glide_delay_top.sv =====
// Glide-delay allpass shaper, top level: sequencer, datapath and checks.
//
// Takes one signed 24-bit audio word, quarters it, shapes its magnitude with a
// sine polynomial, runs it through a 0.618 allpass whose delay length moves one
// cell per word toward delay_target (snapping when the gap exceeds 1500), softens
// it by 1-cos, scales by 4, mixes with the dry word by wet_level and saturates.
// A new word is taken only after the last one has reached the output register;
// the pace is set by the single shared 34x34 multiplier (one product plus one
// rounding step per Horner term, 16 products per word), the single-port delay
// memory and any output stall. After reset the 1502-entry delay memory is zeroed,
// one entry per clock, and no input is taken until the clear is done; config
// writes are taken at any time but are meant to land while the block is idle.
// The result sits in an output register, so the next word may be taken while
// it waits.
module saturated_allpass_glide_delay_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [23:0] sample_in
    input  logic        i_s_axis_tlast,   // block_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [23:0] sample_out
    output logic        o_m_axis_tlast,   // block_last_out
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,      // 0 delay_target, 1 wet_level
    input  logic [16:0] i_cfg_data
);
    import sagd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sagd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sagd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_sample    (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_sample    (o_m_axis_tdata),
        .o_last      (o_m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_FIN) |-> sts.out_free)
        else $error("result loaded over an untaken word");
    a_load_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> (cmd.op == OP_LOAD))
        else $error("accepted word not loaded");
    a_ready_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> sts.clr_done)
        else $error("input taken before memory clear finished");
    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_LOAD) |=> !o_s_axis_tready)
        else $error("ready while a word is in flight");
`endif

endmodule

// ===== rtl/sagd_ctrl.sv =====
// Shaper sequencer: one datapath operation per cycle unless it waits.
module sagd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sagd_pkg::t_sts i_sts,
    output sagd_pkg::t_cmd o_cmd
);
    import sagd_pkg::*;

    t_state     r_state, n_state;
    logic       r_cos, n_cos;
    logic [2:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cos   <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cos   <= n_cos;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cos      = r_cos;
        n_k        = r_k;
        o_in_ready = 1'b0;
        o_cmd      = '{op: OP_NOP, cos_sel: r_cos, k: r_k};
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
                else                o_cmd.op = OP_CLR;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_cos    = 1'b0;
                    n_state  = ST_SQ;
                end
            end
            ST_SQ: begin
                o_cmd.op = OP_MSQ;
                n_state  = ST_USET;
            end
            ST_USET: begin
                o_cmd.op = OP_USET;
                n_k      = '0;
                n_state  = ST_HMUL;
            end
            ST_HMUL: begin
                o_cmd.op = OP_MHORN;
                n_state  = ST_HPOST;
            end
            ST_HPOST: begin
                o_cmd.op = OP_HPOST;
                if (r_k == (r_cos ? COS_LAST_K : SIN_LAST_K)) begin
                    n_state = ST_FMUL;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = ST_HMUL;
                end
            end
            ST_FMUL: begin
                o_cmd.op = r_cos ? OP_MHORN : OP_MFIN_S;
                n_state  = ST_FPOST;
            end
            ST_FPOST: begin
                o_cmd.op = r_cos ? OP_COSF : OP_SINF;
                if (r_cos)                n_state = ST_MX1;
                else if (i_sts.glide_act) n_state = ST_RD0;
                else                      n_state = ST_RDA;
            end
            ST_RD0: begin o_cmd.op = OP_RD0; n_state = ST_RDG; end
            ST_RDG: begin o_cmd.op = OP_RDG; n_state = ST_WRG; end
            ST_WRG: begin o_cmd.op = OP_WRG; n_state = ST_RDA; end
            ST_RDA: begin o_cmd.op = OP_RDA; n_state = ST_MG1; end
            ST_MG1: begin o_cmd.op = OP_MG1; n_state = ST_AP1; end
            ST_AP1: begin o_cmd.op = OP_AP1; n_state = ST_WRX; end
            ST_WRX: begin o_cmd.op = OP_WRX; n_state = ST_MG2; end
            ST_MG2: begin o_cmd.op = OP_MG2; n_state = ST_AP2; end
            ST_AP2: begin o_cmd.op = OP_AP2; n_state = ST_RDB; end
            ST_RDB: begin o_cmd.op = OP_RDB; n_state = ST_ADD; end
            ST_ADD: begin o_cmd.op = OP_ADD; n_state = ST_PREC; end
            ST_PREC: begin
                o_cmd.op = OP_PREC;
                n_cos    = 1'b1;
                n_state  = ST_SQ;
            end
            ST_MX1:  begin o_cmd.op = OP_MX1;  n_state = ST_MXP1; end
            ST_MXP1: begin o_cmd.op = OP_MXP1; n_state = ST_MX2;  end
            ST_MX2:  begin o_cmd.op = OP_MX2;  n_state = ST_MXP2; end
            ST_MXP2: begin o_cmd.op = OP_MXP2; n_state = ST_FIN;  end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_FIN;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

endmodule

// ===== rtl/sagd_dp.sv =====
// Datapath: delay memory, shared multiplier, rounding, glide and config registers.
module sagd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sagd_pkg::t_cmd                    i_cmd,
    output sagd_pkg::t_sts                    o_sts,
    input  logic [sagd_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                              i_last,
    input  logic                              i_cfg_wr_en,
    input  logic [sagd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sagd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [sagd_pkg::SAMPLE_W-1:0]     o_sample,
    output logic                              o_last
);
    import sagd_pkg::*;

    localparam logic signed [14:0] GAP_S = 15'(SNAP_GAP);

    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF)        return 32'h7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)  return 32'h8000_0000;
        else                             return v[31:0];
    endfunction

    // control state
    logic [ADDR_W-1:0]   r_tgt_cfg;
    logic [16:0]         r_wet_cfg;
    logic [13:0]         r_cur;
    logic [ADDR_W-1:0]   r_wpos;
    logic [ADDR_W-1:0]   r_clr;
    logic                r_clr_done;
    logic                r_gact;
    logic                r_out_valid;

    // payload
    logic [31:0]         r_mem [0:DEPTH-1];
    logic signed [31:0]  r_rd, r_d0, r_x, r_t;
    logic [ADDR_W-1:0]   r_gsrc;
    logic signed [23:0]  r_s;
    logic                r_last;
    logic [28:0]         r_a;
    logic [29:0]         r_u;
    logic [32:0]         r_acc;
    logic [67:0]         r_prod;
    logic                r_pneg;
    logic [31:0]         r_m;
    logic signed [35:0]  r_wet;
    logic signed [51:0]  r_mix;
    logic [23:0]         r_out_data;
    logic                r_out_last;

    // glide and address logic
    logic [ADDR_W-1:0]   tgt, cur, pos, ap_addr, mem_addr;
    logic signed [14:0]  gdiff;
    logic [13:0]         curs;
    logic                snap;
    logic                mem_we, mem_re;
    logic [31:0]         mem_wd;
    logic signed [32:0]  gsum;

    always_comb begin
        tgt   = (r_tgt_cfg > ADDR_W'(MAX_DELAY)) ? ADDR_W'(MAX_DELAY) : r_tgt_cfg;
        gdiff = $signed({1'b0, r_cur}) - $signed({4'b0, tgt});
        snap  = (gdiff > GAP_S) || (gdiff < -GAP_S);
        curs  = snap ? {3'b0, tgt} : r_cur;
        cur   = r_cur[ADDR_W-1:0];
        pos   = (r_wpos > ADDR_W'(MAX_DELAY)) ? cur : r_wpos;
        // previous tap and next write position share one rule
        ap_addr = (pos == '0 || {1'b0, pos} > ({1'b0, cur} + 12'd1)) ? cur : pos - 1'b1;
        gsum  = {r_d0[31], r_d0} + {r_rd[31], r_rd};
    end

    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wd = r_x;
        case (i_cmd.op)
            OP_CLR: begin mem_addr = r_clr; mem_we = 1'b1; mem_wd = '0; end
            OP_RD0: begin mem_addr = '0;     mem_re = 1'b1; end
            OP_RDG: begin mem_addr = r_gsrc; mem_re = 1'b1; end
            OP_WRG: begin mem_addr = cur; mem_we = 1'b1; mem_wd = gsum[32:1]; end
            OP_WRX: begin mem_addr = pos; mem_we = 1'b1; end
            OP_RDA, OP_RDB: begin mem_addr = ap_addr; mem_re = 1'b1; end
            default: mem_addr = ap_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wd;
        if (mem_re) r_rd <= r_mem[mem_addr];
    end

    // shared multiplier on magnitudes
    logic [33:0] mul_a, mul_b;
    logic        mul_neg, mul_en;
    logic [31:0] rd_mag, x_mag;
    logic [35:0] wet_abs;
    logic [23:0] s_mag;
    logic [16:0] wl, wl_inv;

    always_comb begin
        rd_mag  = r_rd[31] ? (~r_rd + 32'd1) : r_rd;
        x_mag   = r_x[31] ? (~r_x + 32'd1) : r_x;
        wet_abs = r_wet[35] ? (~r_wet + 36'd1) : r_wet;
        s_mag   = r_s[23] ? (~r_s + 24'd1) : r_s;
        wl      = (r_wet_cfg > WET_FULL) ? WET_FULL : r_wet_cfg;
        wl_inv  = WET_FULL - wl;
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_en  = 1'b1;
        case (i_cmd.op)
            OP_MSQ:    begin mul_a = {5'b0, r_a}; mul_b = {5'b0, r_a}; end
            OP_MHORN:  begin mul_a = {4'b0, r_u}; mul_b = {1'b0, r_acc}; end
            OP_MFIN_S: begin mul_a = {5'b0, r_a}; mul_b = {1'b0, r_acc}; end
            OP_MG1: begin
                mul_a = {2'b0, rd_mag}; mul_b = {3'b0, GAIN_Q31}; mul_neg = r_rd[31];
            end
            OP_MG2: begin
                mul_a = {2'b0, x_mag}; mul_b = {3'b0, GAIN_Q31}; mul_neg = r_x[31];
            end
            OP_MX1: begin
                mul_a = {6'b0, s_mag, 4'b0}; mul_b = {17'b0, wl_inv}; mul_neg = r_s[23];
            end
            OP_MX2: begin
                mul_a = wet_abs[33:0]; mul_b = {17'b0, wl}; mul_neg = r_wet[35];
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= {34'b0, mul_a} * {34'b0, mul_b};
            r_pneg <= mul_neg;
        end
    end

    // rounding of the registered product
    logic [67:0]        rnd27, rnd31, rnd32;
    logic signed [33:0] g_s;
    logic signed [34:0] ap_diff, ap_sum;
    logic [31:0]        sin_x;
    logic signed [33:0] w, wsg;
    logic signed [51:0] p_s;
    logic [51:0]        mix_mag;
    logic [51:0]        mix_rnd;
    logic [23:0]        fin_val;
    logic               x_pos;

    always_comb begin
        rnd27   = (r_prod + (68'd1 << 26)) >> 27;
        rnd31   = (r_prod + (68'd1 << 30)) >> 31;
        rnd32   = (r_prod + (68'd1 << 31)) >> 32;
        g_s     = r_pneg ? -$signed({1'b0, rnd31[32:0]}) : $signed({1'b0, rnd31[32:0]});
        ap_diff = {{3{r_x[31]}}, r_x} - {g_s[33], g_s};
        ap_sum  = {{3{r_t[31]}}, r_t} + {{3{r_rd[31]}}, r_rd};
        sin_x   = (r_s[23] || r_s == '0) ? (~{6'b0, rnd32[25:0]} + 32'd1)
                                         : {6'b0, rnd32[25:0]};
        x_pos   = !r_x[31] && (r_x != '0);
        w       = $signed({2'b0, r_m}) - $signed({4'b0, rnd32[29:0]});
        wsg     = x_pos ? w : -w;
        p_s     = r_pneg ? -$signed({1'b0, r_prod[50:0]}) : $signed({1'b0, r_prod[50:0]});
        mix_mag = r_mix[51] ? (~r_mix + 52'd1) : r_mix;
        mix_rnd = (mix_mag + (52'd1 << 19)) >> 20;
        if (!r_mix[51])
            fin_val = (mix_rnd > 52'h7F_FFFF) ? 24'h7F_FFFF : mix_rnd[23:0];
        else
            fin_val = (mix_rnd > 52'h80_0000) ? 24'h80_0000 : (~mix_rnd[23:0] + 24'd1);
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_s    <= i_sample;
                r_last <= i_last;
                r_a    <= {3'b0, (i_sample[23] ? (~i_sample + 24'd1) : i_sample), 2'b0};
                r_gsrc <= (curs < {3'b0, tgt}) ? curs[ADDR_W-1:0]
                                               : ADDR_W'(curs - 14'd1);
            end
            OP_RDG:  r_d0  <= r_rd;
            OP_USET: begin
                r_u   <= rnd27[29:0];
                r_acc <= i_cmd.cos_sel ? COS_C0 : SIN_C0;
            end
            OP_HPOST: r_acc <= horner_coef(i_cmd.cos_sel, i_cmd.k) - rnd27[32:0];
            OP_SINF:  r_x   <= sin_x;
            OP_AP1:   r_x   <= sat32(ap_diff);
            OP_AP2:   r_t   <= g_s[31:0];
            OP_ADD:   r_x   <= sat32(ap_sum);
            OP_PREC: begin
                r_m <= x_mag;
                r_a <= (x_mag > {3'b0, SOFT_CLAMP}) ? SOFT_CLAMP : x_mag[28:0];
            end
            OP_COSF:  r_wet <= {wsg, 2'b00};
            OP_MXP1:  r_mix <= p_s;
            OP_MXP2:  r_mix <= r_mix + p_s;
            OP_FIN: begin
                r_out_data <= fin_val;
                r_out_last <= r_last;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_cfg   <= '0;
            r_wet_cfg   <= WET_FULL;
            r_cur       <= 14'd9001;
            r_wpos      <= ADDR_W'(1);
            r_clr       <= '0;
            r_clr_done  <= 1'b0;
            r_gact      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_DELAY_TARGET: r_tgt_cfg <= i_cfg_data[ADDR_W-1:0];
                    REG_WET_LEVEL:    r_wet_cfg <= i_cfg_data;
                endcase
            end
            if (i_cmd.op == OP_CLR) begin
                r_clr <= r_clr + 1'b1;
                if (r_clr == ADDR_W'(MAX_DELAY)) r_clr_done <= 1'b1;
            end
            if (i_cmd.op == OP_LOAD) begin
                if (curs < {3'b0, tgt}) begin
                    r_cur  <= curs + 14'd1;
                    r_gact <= 1'b1;
                end else if (curs > {3'b0, tgt}) begin
                    r_cur  <= curs - 14'd1;
                    r_gact <= 1'b1;
                end else begin
                    r_cur  <= curs;
                    r_gact <= 1'b0;
                end
            end
            if (i_cmd.op == OP_RDB) r_wpos <= ap_addr;
            if (i_cmd.op == OP_FIN)  r_out_valid <= 1'b1;
            else if (i_out_ready)    r_out_valid <= 1'b0;
        end
    end

    assign o_sts.clr_done  = r_clr_done;
    assign o_sts.glide_act = r_gact;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_sample        = r_out_data;
    assign o_last          = r_out_last;

endmodule

// ===== tb/tb_saturated_allpass_glide_delay_top.sv =====
// Self-checking testbench for the glide-delay allpass shaper top level.
module tb_saturated_allpass_glide_delay_top;
    import sagd_pkg::*;

    localparam int    WATCHDOG_LIMIT = 20000;
    localparam int    SETTLE_CYCLES  = 80;   // exceeds the worst word latency when the output does not stall
    localparam longint GAIN          = 1327217885;

    typedef struct {
        logic signed [23:0] sample;
        logic               last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tlast = 1'b0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_wr_en = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    saturated_allpass_glide_delay_top u_dut (.*);

    always #10 i_clk = ~i_clk;

    // shaper state mirror
    int          cells [0:MAX_DELAY];
    int          wr_pos;
    int          cur_len;
    logic [10:0] tgt_reg;
    logic [16:0] wet_reg;

    t_word pending_words[$];
    t_word expected_words[$];
    t_word word_on_bus;
    int    in_gap, out_gap;
    int    words_in, words_out, mismatches, idle_cycles;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(5, 1);
        return $urandom_range(200, 20);
    endfunction

    // product over 2^sh, rounded half away from zero
    function automatic longint round_mul(longint a, longint b, int sh);
        logic [63:0] ua, ub, r;
        logic        neg;
        neg = (a < 0) != (b < 0);
        ua  = a < 0 ? -a : a;
        ub  = b < 0 ? -b : b;
        r   = (ua * ub + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [63:0] horner_step(logic [63:0] u, logic [63:0] acc);
        return (u * acc + (64'd1 << 26)) >> 27;
    endfunction

    function automatic logic [63:0] sine_mag(logic [63:0] a);
        logic [63:0] u, acc;
        u   = (a * a + (64'd1 << 26)) >> 27;
        acc = 64'd852176;
        acc = 64'd35791394 - horner_step(u, acc);
        acc = 64'd715827883 - horner_step(u, acc);
        acc = (64'd1 << 32) - horner_step(u, acc);
        return (a * acc + (64'd1 << 31)) >> 32;
    endfunction

    function automatic logic [63:0] versine_mag(logic [63:0] a);
        logic [63:0] u, acc;
        u   = (a * a + (64'd1 << 26)) >> 27;
        acc = 64'd9;
        acc = 64'd1184 - horner_step(u, acc);
        acc = 64'd106522 - horner_step(u, acc);
        acc = 64'd5965232 - horner_step(u, acc);
        acc = 64'd178956971 - horner_step(u, acc);
        acc = 64'd2147483648 - horner_step(u, acc);
        return (u * acc + (64'd1 << 31)) >> 32;
    endfunction

    function automatic int avg_floor(int a, int b);
        longint s;
        s = longint'(a) + longint'(b);
        return int'(s >>> 1);
    endfunction

    function automatic t_word shape_word(t_word w);
        t_word       r;
        longint      s, dry, q, x, wv, wet, mix, wl;
        logic [63:0] m, b;
        int          tgt, ap, pos;
        s   = w.sample;
        dry = s * 16;
        q   = s * 4;
        wl  = wet_reg > WET_FULL ? 65536 : longint'(wet_reg);
        m   = q < 0 ? -q : q;
        x   = longint'(sine_mag(m));
        if (q <= 0) x = -x;
        tgt = tgt_reg > MAX_DELAY ? MAX_DELAY : int'(tgt_reg);
        // glide one cell toward target, snap on a large gap
        if (cur_len - tgt > SNAP_GAP || tgt - cur_len > SNAP_GAP) cur_len = tgt;
        if (cur_len < tgt) begin
            cur_len++;
            cells[cur_len] = avg_floor(cells[0], cells[cur_len - 1]);
        end else if (cur_len > tgt) begin
            cur_len--;
            cells[cur_len] = avg_floor(cells[0], cells[cur_len]);
        end
        pos = wr_pos > MAX_DELAY ? cur_len : wr_pos;
        ap  = pos - 1;
        if (ap < 0 || ap > cur_len) ap = cur_len;
        x = clip(x - round_mul(cells[ap], GAIN, 31), -64'sd2147483648, 64'sd2147483647);
        cells[pos] = int'(x);
        x = round_mul(x, GAIN, 31);
        pos--;
        if (pos < 0 || pos > cur_len) pos = cur_len;
        wr_pos = pos;
        x = clip(x + cells[pos], -64'sd2147483648, 64'sd2147483647);
        // soften: argument of 1-cos clamped at 2.0
        m   = x < 0 ? -x : x;
        b   = versine_mag(m > 64'd268435456 ? 64'd268435456 : m);
        wv  = longint'(m) - longint'(b);
        wet = (x > 0 ? wv : -wv) * 4;
        mix = dry * (65536 - wl) + wet * wl;
        r.sample = 24'(clip(round_mul(mix, 1, 20), -8388608, 8388607));
        r.last   = w.last;
        return r;
    endfunction

    // input driver: feeds words from the pending queue with random gaps
    always @(posedge i_clk) begin
        logic free;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            in_gap = 0;
        end else begin
            free = !i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_words.push_back(shape_word(word_on_bus));
                words_in++;
                free = 1'b1;
            end
            if (free) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    word_on_bus = pending_words.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= word_on_bus.sample;
                    i_s_axis_tlast  <= word_on_bus.last;
                    in_gap = pick_gap();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // output monitor: random back-pressure, compare against oldest expectation
    always @(posedge i_clk) begin
        t_word exp_w;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            words_out++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: data %h last %b", o_m_axis_tdata, o_m_axis_tlast);
            end else begin
                exp_w = expected_words.pop_front();
                if (o_m_axis_tdata !== exp_w.sample || o_m_axis_tlast !== exp_w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected %h/%b, got %h/%b", words_out,
                                 exp_w.sample, exp_w.last, o_m_axis_tdata, o_m_axis_tlast);
                end
            end
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            out_gap = pick_gap();
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_words.size() > 0 || i_s_axis_tvalid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [10:0] tgt, logic [16:0] wet);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_DELAY_TARGET;
        i_cfg_data  <= 17'(tgt);
        tgt_reg = tgt;
        @(posedge i_clk);
        i_cfg_index <= REG_WET_LEVEL;
        i_cfg_data  <= wet;
        wet_reg = wet;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_word(logic [23:0] smp, logic lst);
        t_word w;
        w.sample = smp;
        w.last   = lst;
        pending_words.push_back(w);
    endtask

    function automatic logic [23:0] rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 24'($urandom);
        if (r < 75) return 24'($signed($urandom_range(8192)) - 4096);
        if (r < 90) return 24'($signed($urandom_range(1048576)) - 524288);
        return $urandom_range(1) ? 24'h7fffff : 24'h800000;
    endfunction

    logic [10:0] phase_tgt [8] = '{11'd0, 11'd1501, 11'd2047, 11'd40,
                                   11'd3, 11'd700, 11'd1, 11'd1200};
    logic [16:0] phase_wet [8] = '{17'd65536, 17'd65536, 17'd0, 17'd131071,
                                   17'd32768, 17'd65536, 17'd1000, 17'd70000};

    initial begin
        for (int i = 0; i <= MAX_DELAY; i++) cells[i] = 0;
        wr_pos  = 1;
        cur_len = 9001;
        tgt_reg = '0;
        wet_reg = WET_FULL;
        words_in = 0; words_out = 0; mismatches = 0; idle_cycles = 0; out_gap = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero, tiny values, first-sample snap to target
        set_config(11'd5, 17'd65536);
        queue_word(24'h000000, 1'b0);
        queue_word(24'h7fffff, 1'b0);
        queue_word(24'h800000, 1'b1);
        queue_word(24'h000001, 1'b0);
        queue_word(24'hffffff, 1'b0);
        queue_word(24'h400000, 1'b0);
        queue_word(24'hc00000, 1'b1);
        queue_word(24'h7fffff, 1'b0);
        queue_word(24'h7fffff, 1'b0);
        queue_word(24'h800000, 1'b0);
        queue_word(24'h800000, 1'b1);
        queue_word(24'h555555, 1'b0);
        queue_word(24'haaaaaa, 1'b1);
        drain();

        // random phases across target and wet settings, incl. saturating ones
        for (int p = 0; p < 8; p++) begin
            set_config(phase_tgt[p], phase_wet[p]);
            for (int n = 0; n < 210; n++)
                queue_word(rand_sample(), ($urandom_range(7) == 0));
            drain();
        end

        $display("Covered %0d words in, %0d out, over 9 target/wet settings", words_in, words_out);
        $display("incl. target and wet beyond range, snaps, glides and full-scale input");
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sagd_pkg.sv
rtl/sagd_ctrl.sv
rtl/sagd_dp.sv
rtl/saturated_allpass_glide_delay_top.sv
tb/tb_saturated_allpass_glide_delay_top.sv
